[sv/yuyv_to_planar_yuv420_writer_top_assert.svh]
// assertion macros for the yuyv to planar 4:2:0 writer checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef YUYV_TO_PLANAR_YUV420_WRITER_TOP_ASSERT_SVH
`define YUYV_TO_PLANAR_YUV420_WRITER_TOP_ASSERT_SVH

// plain property under clk_i, off during reset
`define YTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// antecedent implies consequent in the following cycle
`define YTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[sv/ytp_pkg.sv]
// shared types and constants for the yuyv to planar 4:2:0 writer
// no dependencies
package ytp_pkg;

  localparam int ADDR_W      = 25;
  localparam int DATA_W      = 8;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int POS_W       = 13;
  localparam int DIM_W       = 14;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - DATA_W;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // cycles the config-derived plane bases need to settle
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_PITCH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANAR_FMT   = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] RST_PLANE_PITCH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_PLANE_ROWS   = 13'd480;
  localparam logic             RST_PLANAR_FMT   = 1'b1;

  // write slot within one item
  localparam logic [1:0] SUB_Y0 = 2'd0;
  localparam logic [1:0] SUB_Y1 = 2'd1;
  localparam logic [1:0] SUB_U  = 2'd2;
  localparam logic [1:0] SUB_V  = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] pitch;
    logic [CFG_W-1:0] rows;
    logic             fmt;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] u_base;
    logic [ADDR_W-1:0] v_base;
  } base_t;

  typedef struct packed {
    logic [ADDR_W-1:0] y_prod;
    logic [ADDR_W-1:0] uv_prod;
    logic [POS_W-1:0]  col;
    logic [DATA_W-1:0] y0;
    logic [DATA_W-1:0] u;
    logic [DATA_W-1:0] y1;
    logic [DATA_W-1:0] v;
    logic              even_row;
    logic              frame_end;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[sv/yuyv_to_planar_yuv420_writer_top.sv]
// top level of the yuyv 4:2:2 to planar 4:2:0 byte write generator
// uses ytp_pkg, ytp_front, ytp_queue, ytp_back
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   one yuyv macropixel
//  m_axis    out  m_axis_tvalid/m_axis_tready   one byte write
//  cfg       in   cfg_valid_i/cfg_ready_o       register index and value
//
// an even-row item gives four byte writes and an odd-row item two at the output,
// one byte write per cycle through the single output register while it is not stalled
// a suppressed item is accepted at the input and leaves no writes
// the input takes items back to back until the 4-entry queue fills
// after reset and after each config write the input is held off
// while the chroma plane bases are recomputed
module yuyv_to_planar_yuv420_writer_top #(
  parameter int MAX_WIDTH  = ytp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ytp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // luma_first, chroma_blue, luma_second, chroma_red
  input  logic [ytp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // write_address, write_data, zero fill
  output logic [ytp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,
  // frame_done
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ytp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ytp_pkg::CFG_W-1:0]            cfg_data_i
);
  import ytp_pkg::*;

  cfg_t              cfg_q;
  logic              cfg_we;
  logic              push, pop;
  entry_t            entry, head;
  base_t             base;
  qstat_t            qstat;
  logic [ADDR_W-1:0] out_addr;
  logic [DATA_W-1:0] out_data;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= RST_FRAME_WIDTH;
      cfg_q.height <= RST_FRAME_HEIGHT;
      cfg_q.pitch  <= RST_PLANE_PITCH;
      cfg_q.rows   <= RST_PLANE_ROWS;
      cfg_q.fmt    <= RST_PLANAR_FMT;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  cfg_q.width  <= cfg_data_i;
        REG_FRAME_HEIGHT: cfg_q.height <= cfg_data_i;
        REG_PLANE_PITCH:  cfg_q.pitch  <= cfg_data_i;
        REG_PLANE_ROWS:   cfg_q.rows   <= cfg_data_i;
        REG_PLANAR_FMT:   cfg_q.fmt    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  ytp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cfg_we_i  (cfg_we),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_data_i (s_axis_tdata),
    .qstat_i   (qstat),
    .push_o    (push),
    .entry_o   (entry),
    .base_o    (base)
  );

  ytp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .qstat_o(qstat)
  );

  ytp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .qstat_i    (qstat),
    .base_i     (base),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_addr_o (out_addr),
    .out_data_o (out_data),
    .out_last_o (m_axis_tlast),
    .out_done_o (m_axis_tuser)
  );

  // output packing
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_data, out_addr};

endmodule

[sv/ytp_front.sv]
// front part: accepts macropixels, keeps row and column counters,
// forms the row products and the plane bases; uses ytp_pkg
module ytp_front #(
  parameter int MAX_WIDTH  = ytp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ytp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ytp_pkg::cfg_t                      cfg_i,
  input  logic                               cfg_we_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ytp_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  ytp_pkg::qstat_t                    qstat_i,
  output logic                               push_o,
  output ytp_pkg::entry_t                    entry_o,
  output ytp_pkg::base_t                     base_o
);
  import ytp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic [SETTLE_W-1:0] settle_q, settle_d;
  logic [DIM_W-1:0]    w_ext, h_ext, w_eff, h_eff, col_plus, row_plus;
  logic                row_end, frame_end, accept;
  logic [RW+CFG_W-1:0]     y_prod;
  logic [RW+CFG_W-3:0]     uv_prod;
  logic [2*CFG_W-1:0]      u_prod;
  logic [2*CFG_W-3:0]      hh_prod;
  logic [ADDR_W-1:0]       u_base_q, hh_q, v_base_q;

  // saturated frame size
  assign w_ext = DIM_W'(cfg_i.width);
  assign h_ext = DIM_W'(cfg_i.height);
  assign w_eff = (w_ext > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : w_ext;
  assign h_eff = (h_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_ext;

  // row and frame end
  assign col_plus  = DIM_W'(col_q) + DIM_W'(2);
  assign row_plus  = DIM_W'(row_q) + DIM_W'(1);
  assign row_end   = col_plus >= w_eff;
  assign frame_end = row_end && (row_plus >= h_eff);

  // hold off after reset and config writes while the bases settle
  assign in_ready_o = !qstat_i.full && (settle_q == '0) && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && cfg_i.fmt;

  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = SETTLE_CYCLES;
    end else if (settle_q != '0) begin
      settle_d = settle_q - SETTLE_W'(1);
    end
  end

  // counter advance, also for suppressed items
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : RW'(row_plus);
      end else begin
        col_d = CW'(col_plus);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      settle_q <= SETTLE_CYCLES;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      settle_q <= settle_d;
    end
  end

  // row products, registered by the queue storage
  assign y_prod  = row_q * cfg_i.pitch;
  assign uv_prod = row_q[RW-1:1] * cfg_i.pitch[CFG_W-1:1];

  always_comb begin
    entry_o.y_prod    = ADDR_W'(y_prod);
    entry_o.uv_prod   = ADDR_W'(uv_prod);
    entry_o.col       = POS_W'(col_q);
    entry_o.y0        = in_data_i[7:0];
    entry_o.u         = in_data_i[15:8];
    entry_o.y1        = in_data_i[23:16];
    entry_o.v         = in_data_i[31:24];
    entry_o.even_row  = !row_q[0];
    entry_o.frame_end = frame_end;
  end

  // chroma plane bases from the config registers
  assign u_prod  = cfg_i.pitch * cfg_i.rows;
  assign hh_prod = cfg_i.pitch[CFG_W-1:1] * cfg_i.rows[CFG_W-1:1];

  always_ff @(posedge clk_i) begin
    u_base_q <= ADDR_W'(u_prod);
    hh_q     <= ADDR_W'(hh_prod);
    v_base_q <= u_base_q + hh_q;
  end

  assign base_o.u_base = u_base_q;
  assign base_o.v_base = v_base_q;

endmodule

[sv/ytp_queue.sv]
// short fifo of classified items between front and back
// uses ytp_pkg
module ytp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ytp_pkg::entry_t entry_i,
  input  logic            pop_i,
  output ytp_pkg::entry_t head_o,
  output ytp_pkg::qstat_t qstat_o
);
  import ytp_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign qstat_o.full  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

[sv/ytp_back.sv]
// back part: steps through the byte writes of the head item into
// the output register; uses ytp_pkg
module ytp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ytp_pkg::entry_t            head_i,
  input  ytp_pkg::qstat_t            qstat_i,
  input  ytp_pkg::base_t             base_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ytp_pkg::ADDR_W-1:0] out_addr_o,
  output logic [ytp_pkg::DATA_W-1:0] out_data_o,
  output logic                       out_last_o,
  output logic                       out_done_o
);
  import ytp_pkg::*;

  logic [1:0]        sub_q, sub_d;
  logic              valid_q, adv, last_hit;
  logic [ADDR_W-1:0] add_a, add_b, add_c, addr_d, addr_q;
  logic [DATA_W-1:0] data_d, data_q;
  logic              last_q, done_q;

  assign adv      = !qstat_i.empty && (!valid_q || out_ready_i);
  assign last_hit = head_i.even_row ? (sub_q == SUB_V) : (sub_q == SUB_Y1);
  assign pop_o    = adv && last_hit;

  // address terms and data byte for the current slot
  always_comb begin
    add_a  = head_i.y_prod;
    add_b  = '0;
    add_c  = ADDR_W'(head_i.col);
    data_d = head_i.y0;
    unique case (sub_q)
      SUB_Y0: begin
        data_d = head_i.y0;
      end
      SUB_Y1: begin
        add_c  = ADDR_W'({head_i.col[POS_W-1:1], 1'b1});
        data_d = head_i.y1;
      end
      SUB_U: begin
        add_a  = base_i.u_base;
        add_b  = head_i.uv_prod;
        add_c  = ADDR_W'(head_i.col[POS_W-1:1]);
        data_d = head_i.u;
      end
      SUB_V: begin
        add_a  = base_i.v_base;
        add_b  = head_i.uv_prod;
        add_c  = ADDR_W'(head_i.col[POS_W-1:1]);
        data_d = head_i.v;
      end
      default: begin
        data_d = head_i.y0;
      end
    endcase
  end

  assign addr_d = add_a + add_b + add_c;

  always_comb begin
    sub_d = sub_q;
    if (adv) begin
      sub_d = last_hit ? SUB_Y0 : sub_q + 2'd1;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= SUB_Y0;
      valid_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
      if (adv) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= last_hit;
      done_q <= last_hit && head_i.frame_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_addr_o  = addr_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;
  assign out_done_o  = done_q;

endmodule

[sv/ytp_checker.sv]
// port-level checks for the yuyv to planar 4:2:0 writer, bound to the top
// uses ytp_pkg and yuyv_to_planar_yuv420_writer_top_assert.svh
`include "yuyv_to_planar_yuv420_writer_top_assert.svh"

module ytp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [ytp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input logic                                 m_axis_tlast,
  input logic                                 m_axis_tuser,
  input logic                                 cfg_valid_i,
  input logic                                 cfg_ready_o
);
  import ytp_pkg::*;

  logic out_stall, out_take;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_take  = m_axis_tvalid && m_axis_tready;

  // a stalled write holds
  `YTP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // frame end only on the closing write of an item
  `YTP_ASSERT(a_done_is_last, !m_axis_tvalid || !m_axis_tuser || m_axis_tlast)

  // input held off while the plane bases settle after a config write
  `YTP_ASSERT_NEXT(a_cfg_holdoff, cfg_valid_i && cfg_ready_o, !s_axis_tready)

  // fill bits above the data byte stay zero on every write
  `YTP_ASSERT(a_pad_zero, !out_take || (m_axis_tdata[OUT_TDATA_W-1:ADDR_W+DATA_W] == '0))

endmodule

bind yuyv_to_planar_yuv420_writer_top ytp_checker u_ytp_checker (.*);

[tb/yuyv_to_planar_yuv420_writer_top_test.sv]
// self-checking testbench for the yuyv 4:2:2 to planar 4:2:0 byte write generator
// drives macropixel items and config writes, predicts every byte write and compares
// depends on ytp_pkg and yuyv_to_planar_yuv420_writer_top
`timescale 1ns / 100ps

module yuyv_to_planar_yuv420_writer_top_test;
  import ytp_pkg::*;

  localparam int MAX_W          = DEF_MAX_WIDTH;
  localparam int MAX_H          = DEF_MAX_HEIGHT;
  localparam int IDLE_PCT       = 37;
  localparam int STALL_CYCLES   = 300;
  localparam int SETTLE_LATENCY = 16;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int MAX_REPORTS    = 50;
  localparam int RAND_PHASES    = 8;
  localparam int RAND_ITEMS     = 10;
  localparam int PRESS_PHASE    = 3;
  localparam int QUIET_PHASE    = 5;
  // an index outside the register map, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // one yuyv macropixel, luma_first in the lowest byte
  typedef struct packed {
    logic [DATA_W-1:0] chroma_red;
    logic [DATA_W-1:0] luma_second;
    logic [DATA_W-1:0] chroma_blue;
    logic [DATA_W-1:0] luma_first;
  } macropixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              done;
  } byte_write_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  macropixel_t pending_pixels[$];
  byte_write_t expected_writes[$];

  // shadow of the block's registers and raster counters
  cfg_t        shadow_cfg = '{width: RST_FRAME_WIDTH, height: RST_FRAME_HEIGHT,
                              pitch: RST_PLANE_PITCH, rows: RST_PLANE_ROWS,
                              fmt: RST_PLANAR_FMT};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  logic        pixel_taken     = 1'b0;
  bit          sender_steady   = 1'b0;
  bit          receiver_steady = 1'b0;
  bit          press_phase     = 1'b0;
  logic        press_done      = 1'b0;
  int          stall_left      = 0;

  int          error_count   = 0;
  int          pixels_sent   = 0;
  int          writes_seen   = 0;
  int          frames_ended  = 0;
  int          reg_writes    = 0;
  int          settings_used = 0;
  byte_write_t want;

  yuyv_to_planar_yuv420_writer_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic push_write(input longint unsigned addr, input logic [DATA_W-1:0] data,
                            input logic last, input logic done);
    byte_write_t w;
    w.addr = addr[ADDR_W-1:0];
    w.data = data;
    w.last = last;
    w.done = done;
    expected_writes.push_back(w);
  endtask

  // byte writes caused by one macropixel, then counter advance
  task automatic predict_writes(input macropixel_t px);
    int unsigned     width;
    int unsigned     height;
    longint unsigned pitch;
    longint unsigned half_pitch;
    longint unsigned u_base;
    longint unsigned v_base;
    longint unsigned uv_idx;
    longint unsigned y_addr;
    bit              row_end;
    bit              frame_end;
    width     = (shadow_cfg.width > MAX_W) ? MAX_W : shadow_cfg.width;
    height    = (shadow_cfg.height > MAX_H) ? MAX_H : shadow_cfg.height;
    row_end   = (col_pos + 2) >= width;
    frame_end = row_end && ((row_pos + 1) >= height);
    if (shadow_cfg.fmt) begin
      pitch      = shadow_cfg.pitch;
      half_pitch = pitch / 2;
      y_addr     = row_pos * pitch + col_pos;
      u_base     = pitch * shadow_cfg.rows;
      v_base     = u_base + half_pitch * (shadow_cfg.rows / 2);
      uv_idx     = (row_pos / 2) * half_pitch + col_pos / 2;
      push_write(y_addr, px.luma_first, 1'b0, 1'b0);
      if (row_pos % 2 == 0) begin
        push_write(y_addr + 1, px.luma_second, 1'b0, 1'b0);
        push_write(u_base + uv_idx, px.chroma_blue, 1'b0, 1'b0);
        push_write(v_base + uv_idx, px.chroma_red, 1'b1, frame_end);
      end else begin
        push_write(y_addr + 1, px.luma_second, 1'b1, frame_end);
      end
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 2;
    end
    if (frame_end) frames_ended++;
  endtask

  // item driver, fed from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || pixel_taken) begin
        if (pending_pixels.size() != 0 &&
            (sender_steady || $urandom_range(99) >= IDLE_PCT)) begin
          s_axis_tdata  <= pending_pixels.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off during the pressure phase
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (press_phase && !press_done) begin
        stall_left <= STALL_CYCLES;
        press_done <= 1'b1;
      end
    end
  end

  // receiver ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= (stall_left == 0) &&
                       (receiver_steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: config shadow, prediction on accepted items, write check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      pixel_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid_i && cfg_ready_o) begin
        reg_writes++;
        case (cfg_index_i)
          REG_FRAME_WIDTH:  shadow_cfg.width  = cfg_data_i;
          REG_FRAME_HEIGHT: shadow_cfg.height = cfg_data_i;
          REG_PLANE_PITCH:  shadow_cfg.pitch  = cfg_data_i;
          REG_PLANE_ROWS:   shadow_cfg.rows   = cfg_data_i;
          REG_PLANAR_FMT:   shadow_cfg.fmt    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pixels_sent++;
        predict_writes(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write to %h", m_axis_tdata[ADDR_W-1:0]));
        end else begin
          want = expected_writes.pop_front();
          if (m_axis_tdata[ADDR_W-1:0] !== want.addr)
            report_mismatch($sformatf("write %0d address %h, expected %h", writes_seen,
                                      m_axis_tdata[ADDR_W-1:0], want.addr));
          if (m_axis_tdata[ADDR_W+DATA_W-1:ADDR_W] !== want.data)
            report_mismatch($sformatf("write %0d data %h, expected %h", writes_seen,
                                      m_axis_tdata[ADDR_W+DATA_W-1:ADDR_W], want.data));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("write %0d last %b, expected %b", writes_seen,
                                      m_axis_tlast, want.last));
          if (m_axis_tuser !== want.done)
            report_mismatch($sformatf("write %0d frame done %b, expected %b", writes_seen,
                                      m_axis_tuser, want.done));
        end
        writes_seen++;
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // format flag in bit 0, the upper bits are don't-care noise
  function automatic logic [CFG_W-1:0] fmt_word(input bit f);
    logic [CFG_W-1:0] w;
    w    = CFG_W'($urandom_range((1 << CFG_W) - 1));
    w[0] = f;
    return w;
  endfunction

  task automatic set_frame(input int w, input int h, input int p, input int r, input bit f);
    cfg_write(REG_FRAME_WIDTH, w[CFG_W-1:0]);
    cfg_write(REG_FRAME_HEIGHT, h[CFG_W-1:0]);
    cfg_write(REG_PLANE_PITCH, p[CFG_W-1:0]);
    cfg_write(REG_PLANE_ROWS, r[CFG_W-1:0]);
    cfg_write(REG_PLANAR_FMT, fmt_word(f));
    settings_used++;
  endtask

  task automatic push_random(input int n);
    repeat (n) pending_pixels.push_back($urandom());
  endtask

  // wait for all items and writes, then let a suppressed item finish
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    while ((pending_pixels.size() != 0 || s_axis_tvalid || expected_writes.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_LATENCY) @(posedge clk_i);
    if (expected_writes.size() != 0) begin
      report_mismatch($sformatf("%0d expected writes never arrived", expected_writes.size()));
      expected_writes.delete();
    end
  endtask

  // stimulus
  initial begin
    int w;
    int h;
    int p;
    int r;
    bit f;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, byte extremes
    settings_used++;
    pending_pixels.push_back(32'h0000_0000);
    pending_pixels.push_back(32'hFFFF_FFFF);
    pending_pixels.push_back(32'h5AA5_C33C);
    drain_and_settle();

    // zero width and height, all-ones odd pitch and rows, chroma base wraps
    set_frame(0, 0, 8191, 8191, 1'b1);
    pending_pixels.push_back(32'hFF00_FF00);
    pending_pixels.push_back(32'h00FF_00FF);
    push_random(1);
    drain_and_settle();

    // small frame with odd pitch and rows, wraps into the next frame
    set_frame(4, 3, 7, 5, 1'b1);
    push_random(7);
    drain_and_settle();

    // writes suppressed, counters keep moving
    cfg_write(REG_PLANAR_FMT, fmt_word(1'b0));
    settings_used++;
    push_random(2);
    drain_and_settle();
    cfg_write(REG_PLANAR_FMT, fmt_word(1'b1));
    cfg_write(REG_UNUSED, CFG_W'($urandom_range((1 << CFG_W) - 1)));
    settings_used++;
    push_random(2);
    drain_and_settle();

    // oversize width and height saturate
    set_frame(8191, 8191, 4096, 4096, 1'b1);
    push_random(2);
    drain_and_settle();

    // odd width, config changed in the middle of a row
    set_frame(5, 2, 6, 2, 1'b1);
    push_random(4);
    drain_and_settle();

    // random settings, mostly small frames so rows and frames wrap often
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      w = ($urandom_range(2) == 0) ? $urandom_range(8191) : 2 * $urandom_range(1, 8);
      h = ($urandom_range(2) == 0) ? $urandom_range(8191) : $urandom_range(1, 4);
      p = ($urandom_range(2) == 0) ? $urandom_range(8191) : w + 2 * $urandom_range(0, 4);
      r = ($urandom_range(2) == 0) ? $urandom_range(8191) : h + $urandom_range(0, 4);
      // writes stay on in the pressure phase so the queue fills
      f = (ph == PRESS_PHASE) || ($urandom_range(99) < 85);
      set_frame(w, h, p, r, f);
      sender_steady   = (ph == PRESS_PHASE) || (ph == QUIET_PHASE);
      receiver_steady = (ph == QUIET_PHASE);
      press_phase     = (ph == PRESS_PHASE);
      push_random(RAND_ITEMS);
      drain_and_settle();
      press_phase = 1'b0;
    end

    $display("covered %0d macropixels over %0d register settings (%0d register writes)",
             pixels_sent, settings_used, reg_writes);
    $display("checked %0d byte writes, %0d frame ends, %0d mismatches",
             writes_seen, frames_ended, error_count);
    if (error_count == 0) begin
      $display("yuyv_to_planar_yuv420_writer_top_test passed");
    end else begin
      $display("yuyv_to_planar_yuv420_writer_top_test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("yuyv_to_planar_yuv420_writer_top_test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/ytp_pkg.sv
sv/ytp_front.sv
sv/ytp_queue.sv
sv/ytp_back.sv
sv/yuyv_to_planar_yuv420_writer_top.sv
sv/ytp_checker.sv
tb/yuyv_to_planar_yuv420_writer_top_test.sv
